// ===== src/swk_pkg.sv =====
// Shared constants, types and tables for the swerve wheel kinematics core.
package swk_pkg;

    localparam int CordicStagesDef = 16;
    localparam int CordicStagesMax = 24;
    localparam int GuardBits       = 8;
    // Wheel components reach about 21 bits; rotation grows them by under 2 bits.
    localparam int CompW           = 22;
    localparam int CordW           = CompW + GuardBits + 2;
    localparam int AngW            = 34;
    localparam logic [15:0] OffsetReset = 16'd6553;
    localparam logic signed [14:0] HalfPiQ13 = 15'sd12868;
    localparam logic [29:0] InvGain = 30'd652032874;

    // APB register indexes
    localparam logic [0:0] RegWheelOffset = 1'b0;

    typedef logic signed [CordW-1:0] t_cord;
    typedef logic signed [AngW-1:0]  t_ang;

    typedef struct packed {
        logic signed [CompW-1:0] x;
        logic signed [CompW-1:0] y;
    } t_wheel_vec;

    function automatic logic signed [AngW-1:0] atan_q30(input int idx);
        logic [31:0] v;
        begin
            unique case (idx)
                0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
                3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
                6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
                9: v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
                12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
                15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
                18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
                21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
                default: v = 32'h0;
            endcase
            atan_q30 = $signed({2'b00, v});
        end
    endfunction

endpackage

// ===== src/swk_if.sv =====
// Valid/ready stream interface carrying a payload of parameterized width.
interface swk_if #(parameter int W = 48) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/swerve_wheel_kinematics_core.sv =====
// Swerve drive inverse kinematics: four wheel angles and speeds per command.
// Usage:
//  - Input channel (swk_if sink): vel_x, vel_y, yaw_rate, signed 16 bits each,
//    packed {yaw_rate, vel_y, vel_x}.
//  - Output channel (swk_if source): one result per command, packed
//    {speeds rear_right..front_left (16b each), angles rr..fl (15b each)}.
//  - APB port: register 0 at address 0 is wheel_offset (unsigned Q4.12).
//    Write it only while the block is idle.
//  - Each command passes, from accept to result, one stage for the yaw
//    product, one for wheel sums, one pre-rotation, one per CORDIC iteration
//    (CORDIC_STAGES, limited to 24) and one for the gain multiply.
//  - Throughput is one command per cycle while the receiver does not stall;
//    the four wheel CORDIC pipelines run side by side.
//  - Reset clears all pipeline valid bits and loads wheel_offset with 6553.
//  - When the receiver stalls with a result waiting, the whole pipeline
//    holds and no input is taken until that result leaves; nothing is lost.
module swerve_wheel_kinematics_core #(
    parameter int CORDIC_STAGES = swk_pkg::CordicStagesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swk_if.sink         s_in,
    swk_if.source       m_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int N   = (CORDIC_STAGES > swk_pkg::CordicStagesMax) ?
                         swk_pkg::CordicStagesMax : CORDIC_STAGES;
    localparam int LAT = N + 4;

    logic [15:0] r_offset;
    assign pready = 1'b1;
    assign prdata = (paddr[1:1] == swk_pkg::RegWheelOffset) ? {16'd0, r_offset} : 32'd0;

    // Hold the configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= swk_pkg::OffsetReset;
        end else if (psel && penable && pwrite &&
                     paddr[1:1] == swk_pkg::RegWheelOffset) begin
            r_offset <= pwdata[15:0];
        end
    end

    // Valid chain; advance when the output register is empty or being taken
    logic [LAT-1:0] r_vld;
    logic en;
    assign en          = !r_vld[LAT-1] || m_out.ready;
    assign s_in.ready  = en;
    assign m_out.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_in.valid};
        end
    end

    // Stage 1: yaw product
    logic signed [15:0] r_vx, r_vy;
    logic signed [32:0] r_prodk;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vx    <= s_in.data[15:0];
            r_vy    <= s_in.data[31:16];
            r_prodk <= 33'(signed'(s_in.data[47:32])) * signed'({1'b0, r_offset})
                       + 33'sd2048;
        end
    end

    // Stage 2: wheel vectors
    logic signed [20:0] k;
    assign k = r_prodk[32:12];
    swk_pkg::t_wheel_vec r_w [4];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w[0] <= '{x: 22'(r_vx) - 22'(k), y: 22'(r_vy) + 22'(k)};
            r_w[1] <= '{x: 22'(r_vx) + 22'(k), y: 22'(r_vy) + 22'(k)};
            r_w[2] <= '{x: 22'(r_vx) - 22'(k), y: 22'(r_vy) - 22'(k)};
            r_w[3] <= '{x: 22'(r_vx) + 22'(k), y: 22'(r_vy) - 22'(k)};
        end
    end

    logic signed [14:0] ang [4];
    logic signed [15:0] spd [4];
    for (genvar w = 0; w < 4; w++) begin : g_wheel
        swk_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_vec   (r_w[w]),
            .o_angle (ang[w]),
            .o_speed (spd[w])
        );
    end

    assign m_out.data = {spd[3], spd[2], spd[1], spd[0],
                         ang[3], ang[2], ang[1], ang[0]};

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid)
        else $error("result dropped under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_out.valid |-> s_in.ready)
        else $error("input blocked with empty output");
    a_ang: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> (ang[0] <= swk_pkg::HalfPiQ13 && ang[0] >= -swk_pkg::HalfPiQ13))
        else $error("angle out of range");
`endif
endmodule

// ===== src/swk_cordic.sv =====
// Pipelined CORDIC vectoring unit for one wheel, stalls with a shared enable.
module swk_cordic #(
    parameter int CORDIC_STAGES = swk_pkg::CordicStagesDef
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  swk_pkg::t_wheel_vec           i_vec,
    output logic signed [14:0]            o_angle,
    output logic signed [15:0]            o_speed
);
    localparam int N = (CORDIC_STAGES > swk_pkg::CordicStagesMax) ?
                       swk_pkg::CordicStagesMax : CORDIC_STAGES;

    swk_pkg::t_cord r_x [N+1];
    swk_pkg::t_cord r_y [N+1];
    swk_pkg::t_ang  r_z [N+1];
    logic           r_neg  [N+1];
    logic           r_zero [N+1];
    logic [15:0]    r_absy [N+1];

    // Pre-rotate into the right half-plane and add guard bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0]  <= i_vec.x[swk_pkg::CompW-1];
            r_zero[0] <= (i_vec.x == '0);
            r_x[0] <= i_vec.x[swk_pkg::CompW-1] ?
                      (-(swk_pkg::t_cord'(i_vec.x)) <<< swk_pkg::GuardBits) :
                      (swk_pkg::t_cord'(i_vec.x) <<< swk_pkg::GuardBits);
            r_y[0] <= i_vec.x[swk_pkg::CompW-1] ?
                      (-(swk_pkg::t_cord'(i_vec.y)) <<< swk_pkg::GuardBits) :
                      (swk_pkg::t_cord'(i_vec.y) <<< swk_pkg::GuardBits);
            r_z[0] <= '0;
            if (i_vec.y[swk_pkg::CompW-1])
                r_absy[0] <= ((-i_vec.y) > swk_pkg::CompW'(32767)) ? 16'd32767
                             : 16'((-i_vec.y));
            else
                r_absy[0] <= (i_vec.y > swk_pkg::CompW'(32767)) ? 16'd32767
                             : 16'(i_vec.y);
        end
    end

    // Rotate one micro-angle per stage
    for (genvar g = 0; g < N; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[g+1]  <= r_neg[g];
                r_zero[g+1] <= r_zero[g];
                r_absy[g+1] <= r_absy[g];
                if (r_y[g] < 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - swk_pkg::atan_q30(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + swk_pkg::atan_q30(g);
                end
            end
        end
    end

    // Gain multiply and angle rounding
    logic [swk_pkg::CordW+29:0] r_prod;
    logic signed [swk_pkg::AngW-18:0] r_ang;
    logic r_neg_m, r_zero_m;
    logic [15:0] r_absy_m;
    swk_pkg::t_ang n_zr;
    always_comb n_zr = r_z[N] + swk_pkg::t_ang'(65536);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= (swk_pkg::CordW+30)'(unsigned'(r_x[N])) *
                        (swk_pkg::CordW+30)'(swk_pkg::InvGain);
            r_ang    <= n_zr[swk_pkg::AngW-1:17];
            r_neg_m  <= r_neg[N];
            r_zero_m <= r_zero[N];
            r_absy_m <= r_absy[N];
        end
    end

    // Saturate and select the zero-x case
    logic [swk_pkg::CordW+29:0] n_mag;
    always_comb begin
        n_mag = (r_prod + ((swk_pkg::CordW+30)'(1) << 37)) >> 38;
        if (r_zero_m) begin
            o_angle = swk_pkg::HalfPiQ13;
            o_speed = signed'(r_absy_m);
        end else begin
            if (r_ang > 17'(swk_pkg::HalfPiQ13))
                o_angle = swk_pkg::HalfPiQ13;
            else if (r_ang < -17'(swk_pkg::HalfPiQ13))
                o_angle = -swk_pkg::HalfPiQ13;
            else
                o_angle = r_ang[14:0];
            if (r_neg_m)
                o_speed = (n_mag > 32768) ? 16'sh8000 : 16'(-n_mag);
            else
                o_speed = (n_mag > 32767) ? 16'sh7FFF : 16'(n_mag);
        end
    end
endmodule
